// ===== rtl/read_depth_pileup_core_assert.svh =====
// assertion macros of the pileup rtl, used by rdp_ctrl
`ifndef READ_DEPTH_PILEUP_CORE_ASSERT_SVH
`define READ_DEPTH_PILEUP_CORE_ASSERT_SVH

// same-cycle implication, reset masks the check
`define RDP_ASSERT_IMP(lbl, c, r, a, b) \
  lbl: assert property (@(posedge c) disable iff (r) (a) |-> (b)) \
    else $error("lbl failed");

// next-cycle implication, reset masks the check
`define RDP_ASSERT_NXT(lbl, c, r, a, b) \
  lbl: assert property (@(posedge c) disable iff (r) (a) |=> (b)) \
    else $error("lbl failed");

`endif

// ===== rtl/rdp_pkg.sv =====
// shared types, codes and constants of the read depth pileup
package rdp_pkg;

  localparam int WINDOW_DEPTH_DEF = 4096;
  localparam int DEPTH_BITS_DEF   = 16;

  localparam logic [11:0] FLAG_REJECT  = 12'h704;
  localparam logic [11:0] FLAG_REVERSE = 12'h010;
  localparam logic [3:0]  BASE_N       = 4'd15;

  localparam logic [30:0] WINDOW_START_RST = 31'd1;
  localparam logic [30:0] WINDOW_END_RST   = 31'd4096;
  localparam logic        WANT_FWD_RST     = 1'b1;
  localparam logic [6:0]  MIN_QUAL_RST     = 7'd13;

  typedef enum logic [1:0] {
    CMD_READ_START = 2'd0,
    CMD_CIGAR      = 2'd1,
    CMD_BASE       = 2'd2,
    CMD_READOUT    = 2'd3
  } cmd_code_t;

  typedef enum logic [3:0] {
    OP_M   = 4'd0,
    OP_I   = 4'd1,
    OP_D   = 4'd2,
    OP_N   = 4'd3,
    OP_S   = 4'd4,
    OP_H   = 4'd5,
    OP_P   = 4'd6,
    OP_EQ  = 4'd7,
    OP_X   = 4'd8
  } cigar_op_t;

  typedef enum logic [1:0] {
    REG_WINDOW_START = 2'd0,
    REG_WINDOW_END   = 2'd1,
    REG_WANT_FWD     = 2'd2,
    REG_MIN_QUAL     = 2'd3
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_LOOKUP,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic clear_step;
    logic update;
  } ctl_t;

  typedef struct packed {
    logic clear_last;
    logic mem_access;
    logic readout;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/rdp_ctrl.sv =====
// sequencer of the pileup: clearing pass, accept, execute, store access
`include "read_depth_pileup_core_assert.svh"

module rdp_ctrl import rdp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output ctl_t ctl
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (sts.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (sts.mem_access || sts.readout) state_next = ST_LOOKUP;
        else state_next = ST_IDLE;
      end
      ST_LOOKUP: begin
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (!sts.readout || sts.out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    in_ready       = 1'b0;
    ctl            = '0;
    case (state)
      ST_CLEAR: begin
        ctl.clear_step = 1'b1;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        ctl.load = in_valid;
      end
      ST_EXEC: begin
        ctl.exec = 1'b1;
      end
      ST_LOOKUP: begin
      end
      ST_UPDATE: begin
        ctl.update = !sts.readout || sts.out_free;
      end
      default: begin
      end
    endcase
  end

  `RDP_ASSERT_NXT(a_accept_exec, clk, rst, in_valid && in_ready, state == ST_EXEC)
  `RDP_ASSERT_NXT(a_lookup_update, clk, rst, state == ST_LOOKUP, state == ST_UPDATE)
  `RDP_ASSERT_IMP(a_one_action, clk, rst, 1'b1,
                  $onehot0({ctl.load, ctl.exec, ctl.clear_step, ctl.update}))

endmodule

// ===== rtl/rdp_datapath.sv =====
// read state, window arithmetic, depth store and output register
module rdp_datapath import rdp_pkg::*; #(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
  parameter int DEPTH_BITS   = DEPTH_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_data,
  input  logic [1:0]  cmd,
  input  logic [11:0] flag_bits,
  input  logic [30:0] align_pos,
  input  logic [3:0]  cigar_kind,
  input  logic [27:0] cigar_length,
  input  logic [3:0]  base_code,
  input  logic [7:0]  base_quality,
  input  logic [11:0] depth_offset,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] depth,
  input  ctl_t        ctl,
  output sts_t        sts
);

  localparam int AW = $clog2(WINDOW_DEPTH);

  logic [30:0] window_start;
  logic [30:0] window_end;
  logic        want_forward_strand;
  logic [6:0]  min_base_quality;

  logic [1:0]  cmd_r;
  logic [11:0] flags_r;
  logic [30:0] apos_r;
  logic [3:0]  kind_r;
  logic [27:0] len_r;
  logic [3:0]  code_r;
  logic [7:0]  qual_r;
  logic [11:0] offset_r;

  logic        read_accepted;
  logic [31:0] ref_cursor;
  logic [27:0] bases_left;
  logic        counts_bases;

  logic [DEPTH_BITS-1:0] mem [WINDOW_DEPTH];
  logic [DEPTH_BITS-1:0] rdata;
  logic [AW-1:0]         addr_r;
  logic [AW-1:0]         clr_addr;
  logic                  hit;

  logic [31:0] base_off;
  logic        base_in_window;
  logic        base_take;
  logic        base_count;
  logic [31:0] ro_off;
  logic        ro_in_range;
  logic [31:0] skip;
  logic [31:0] ref_move;
  logic        is_readout;

  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [DEPTH_BITS-1:0] mem_wdata;
  logic [DEPTH_BITS-1:0] rdata_inc;
  logic [31:0]           rdata_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_start        <= WINDOW_START_RST;
      window_end          <= WINDOW_END_RST;
      want_forward_strand <= WANT_FWD_RST;
      min_base_quality    <= MIN_QUAL_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_WINDOW_START: window_start        <= cfg_data;
        REG_WINDOW_END:   window_end          <= cfg_data;
        REG_WANT_FWD:     want_forward_strand <= cfg_data[0];
        REG_MIN_QUAL:     min_base_quality    <= cfg_data[6:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r    <= cmd;
      flags_r  <= flag_bits;
      apos_r   <= align_pos;
      kind_r   <= cigar_kind;
      len_r    <= cigar_length;
      code_r   <= base_code;
      qual_r   <= base_quality;
      offset_r <= depth_offset;
    end
  end

  assign is_readout = cmd_r == CMD_READOUT;

  assign base_off       = ref_cursor - {1'b0, window_start};
  assign base_in_window = (ref_cursor >= {1'b0, window_start}) &&
                          (ref_cursor <= {1'b0, window_end}) &&
                          (base_off < 32'(WINDOW_DEPTH));
  assign base_take  = (cmd_r == CMD_BASE) && read_accepted && (bases_left != '0);
  assign base_count = base_take && counts_bases && (code_r != BASE_N) &&
                      (qual_r >= {1'b0, min_base_quality}) && base_in_window;

  assign ro_off      = {20'd0, offset_r};
  assign ro_in_range = ro_off < 32'(WINDOW_DEPTH);

  assign skip     = counts_bases ? {4'd0, bases_left} : 32'd0;
  assign ref_move = (kind_r == OP_D || kind_r == OP_N) ? {4'd0, len_r} : 32'd0;

  // read walk state
  always_ff @(posedge clk) begin
    if (rst) begin
      read_accepted <= 1'b0;
      ref_cursor    <= '0;
      bases_left    <= '0;
      counts_bases  <= 1'b0;
    end else if (ctl.exec) begin
      case (cmd_r)
        CMD_READ_START: begin
          read_accepted <= ((flags_r & FLAG_REJECT) == '0) &&
                           (((flags_r & FLAG_REVERSE) == '0) == want_forward_strand);
          ref_cursor    <= {1'b0, apos_r} + 32'd1;
          bases_left    <= '0;
          counts_bases  <= 1'b0;
        end
        CMD_CIGAR: begin
          if (read_accepted) begin
            ref_cursor <= ref_cursor + skip + ref_move;
            case (kind_r)
              OP_M, OP_EQ, OP_X: begin
                bases_left   <= len_r;
                counts_bases <= 1'b1;
              end
              OP_I, OP_S: begin
                bases_left   <= len_r;
                counts_bases <= 1'b0;
              end
              default: begin
                bases_left   <= '0;
                counts_bases <= 1'b0;
              end
            endcase
          end
        end
        CMD_BASE: begin
          if (base_take) begin
            bases_left <= bases_left - 28'd1;
            if (counts_bases) ref_cursor <= ref_cursor + 32'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      hit    <= is_readout ? ro_in_range : base_count;
      addr_r <= is_readout ? ro_off[AW-1:0] : base_off[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (ctl.clear_step) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  // saturating increment
  assign rdata_inc = (rdata == '1) ? rdata : rdata + DEPTH_BITS'(1);
  assign rdata_ext = 32'(rdata);

  assign mem_we    = ctl.clear_step || (ctl.update && hit);
  assign mem_waddr = ctl.clear_step ? clr_addr : addr_r;
  assign mem_wdata = (ctl.clear_step || is_readout) ? '0 : rdata_inc;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata <= mem[addr_r];
  end

  // output beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.update && is_readout) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.update && is_readout) depth <= hit ? rdata_ext[15:0] : 16'd0;
  end

  assign sts.clear_last = clr_addr == AW'(WINDOW_DEPTH - 1);
  assign sts.mem_access = is_readout ? ro_in_range : base_count;
  assign sts.readout    = is_readout;
  assign sts.out_free   = !out_valid || out_ready;

endmodule

// ===== rtl/read_depth_pileup_core.sv =====
// top level of the read depth pileup core
//
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------------------
//  input    | in_valid / in_ready    | cmd flag_bits align_pos cigar_kind
//           |                        | cigar_length base_code base_quality depth_offset
//  output   | out_valid / out_ready  | depth
//  config   | cfg_write              | cfg_index cfg_data
//
// read start, cigar element and uncounted base: accept, execute
// counted base and readout: accept, execute, lookup, write-back; the store read is registered before write-back
// a readout holds in write-back while the previous depth beat is not taken
// after reset a clearing pass over all WINDOW_DEPTH store entries runs with in_ready low
// config writes are taken in every cycle outside reset
module read_depth_pileup_core import rdp_pkg::*; #(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
  parameter int DEPTH_BITS   = DEPTH_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [11:0] flag_bits,
  input  logic [30:0] align_pos,
  input  logic [3:0]  cigar_kind,
  input  logic [27:0] cigar_length,
  input  logic [3:0]  base_code,
  input  logic [7:0]  base_quality,
  input  logic [11:0] depth_offset,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] depth
);

  ctl_t ctl;
  sts_t sts;

  rdp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  rdp_datapath #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .DEPTH_BITS   (DEPTH_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .flag_bits    (flag_bits),
    .align_pos    (align_pos),
    .cigar_kind   (cigar_kind),
    .cigar_length (cigar_length),
    .base_code    (base_code),
    .base_quality (base_quality),
    .depth_offset (depth_offset),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .depth        (depth),
    .ctl          (ctl),
    .sts          (sts)
  );

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// self-checking testbench of the read depth pileup core with its own coverage tracker
module tb_top;
  import rdp_pkg::*;

  localparam int STORE_DEPTH   = WINDOW_DEPTH_DEF;
  localparam int STALL_LIMIT   = 20000;
  localparam int SETTLE_CYCLES = 8;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  reg_index_t  cfg_index = REG_WINDOW_START;
  logic [30:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  cmd_code_t   cmd = CMD_READ_START;
  logic [11:0] flag_bits = '0;
  logic [30:0] align_pos = '0;
  logic [3:0]  cigar_kind = '0;
  logic [27:0] cigar_length = '0;
  logic [3:0]  base_code = '0;
  logic [7:0]  base_quality = '0;
  logic [11:0] depth_offset = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] depth;

  // coverage tracker state and its copy of the registers
  logic [15:0] cover_mem [STORE_DEPTH] = '{default: 16'h0};
  logic        read_live = 1'b0;
  logic        owed_counts = 1'b0;
  logic [31:0] ref_pos = '0;
  logic [27:0] bases_owed = '0;
  logic [30:0] win_lo = WINDOW_START_RST;
  logic [30:0] win_hi = WINDOW_END_RST;
  logic        keep_fwd = WANT_FWD_RST;
  logic [6:0]  qual_floor = MIN_QUAL_RST;

  logic [15:0] pending_depths [$];
  logic [15:0] want_depth;
  int          fault_count = 0;
  int          beats_sent = 0;
  int          idle_cycles = 0;
  bit          calm = 1'b0;

  read_depth_pileup_core u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .flag_bits    (flag_bits),
    .align_pos    (align_pos),
    .cigar_kind   (cigar_kind),
    .cigar_length (cigar_length),
    .base_code    (base_code),
    .base_quality (base_quality),
    .depth_offset (depth_offset),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .depth        (depth)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= 11);
  end

  task automatic log_fault(input string what, input logic [15:0] exp_d, input logic [15:0] got_d);
    fault_count++;
    if (fault_count <= 10) begin
      $display("%0t %s: expected %h got %h", $time, what, exp_d, got_d);
    end
  endtask

  // depth beat checker
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_depths.size() == 0) begin
        log_fault("depth beat with none pending", 'x, depth);
      end else begin
        want_depth = pending_depths.pop_front();
        if (depth !== want_depth) begin
          log_fault("depth mismatch", want_depth, depth);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  task automatic track_coverage(input cmd_code_t c, input logic [11:0] flags,
                                input logic [30:0] apos, input logic [3:0] kind,
                                input logic [27:0] len, input logic [3:0] code,
                                input logic [7:0] qual, input logic [11:0] off);
    logic [31:0] slot;
    logic        fwd;
    case (c)
      CMD_READ_START: begin
        fwd = ((flags & FLAG_REVERSE) == '0);
        read_live = ((flags & FLAG_REJECT) == '0) && (fwd == keep_fwd);
        ref_pos = {1'b0, apos} + 32'd1;
        bases_owed = '0;
        owed_counts = 1'b0;
      end
      CMD_CIGAR: begin
        if (read_live) begin
          // missing bases of a counting element still move the cursor
          if (owed_counts) ref_pos = ref_pos + {4'd0, bases_owed};
          bases_owed = '0;
          owed_counts = 1'b0;
          case (kind)
            OP_M, OP_EQ, OP_X: begin
              bases_owed = len;
              owed_counts = 1'b1;
            end
            OP_I, OP_S: bases_owed = len;
            OP_D, OP_N: ref_pos = ref_pos + {4'd0, len};
            default: ;
          endcase
        end
      end
      CMD_BASE: begin
        if (read_live && bases_owed != '0) begin
          bases_owed = bases_owed - 28'd1;
          if (owed_counts) begin
            slot = ref_pos - {1'b0, win_lo};
            if (code != BASE_N && qual >= {1'b0, qual_floor} &&
                ref_pos >= {1'b0, win_lo} && ref_pos <= {1'b0, win_hi} &&
                slot < STORE_DEPTH && cover_mem[slot[11:0]] != 16'hFFFF) begin
              cover_mem[slot[11:0]] = cover_mem[slot[11:0]] + 16'd1;
            end
            ref_pos = ref_pos + 32'd1;
          end
        end
      end
      default: begin
        pending_depths = {pending_depths, cover_mem[off]};
        cover_mem[off] = '0;
      end
    endcase
  endtask

  task automatic send_beat(input cmd_code_t c, input logic [11:0] flags,
                           input logic [30:0] apos, input logic [3:0] kind,
                           input logic [27:0] len, input logic [3:0] code,
                           input logic [7:0] qual, input logic [11:0] off);
    while (!calm && $urandom_range(0, 99) < 11) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    cmd          <= c;
    flag_bits    <= flags;
    align_pos    <= apos;
    cigar_kind   <= kind;
    cigar_length <= len;
    base_code    <= code;
    base_quality <= qual;
    depth_offset <= off;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    track_coverage(c, flags, apos, kind, len, code, qual, off);
    beats_sent++;
  endtask

  task automatic start_read(input logic [11:0] flags, input logic [30:0] apos);
    send_beat(CMD_READ_START, flags, apos, 4'($urandom), 28'($urandom), 4'($urandom),
              8'($urandom), 12'($urandom));
  endtask

  task automatic send_cigar(input logic [3:0] kind, input logic [27:0] len);
    send_beat(CMD_CIGAR, 12'($urandom), 31'($urandom), kind, len, 4'($urandom),
              8'($urandom), 12'($urandom));
  endtask

  task automatic send_base(input logic [3:0] code, input logic [7:0] qual);
    send_beat(CMD_BASE, 12'($urandom), 31'($urandom), 4'($urandom), 28'($urandom), code,
              qual, 12'($urandom));
  endtask

  task automatic send_readout(input logic [11:0] off);
    send_beat(CMD_READOUT, 12'($urandom), 31'($urandom), 4'($urandom), 28'($urandom),
              4'($urandom), 8'($urandom), off);
  endtask

  // lets the core run dry before a register write or the end of the run
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_depths.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_window(input logic [30:0] lo, input logic [30:0] hi, input logic fwd,
                            input logic [6:0] floor_q);
    settle();
    cfg_write <= 1'b1;
    cfg_index <= REG_WINDOW_START;
    cfg_data  <= lo;
    @(posedge clk);
    cfg_index <= REG_WINDOW_END;
    cfg_data  <= hi;
    @(posedge clk);
    cfg_index <= REG_WANT_FWD;
    cfg_data  <= {30'd0, fwd};
    @(posedge clk);
    cfg_index <= REG_MIN_QUAL;
    cfg_data  <= {24'd0, floor_q};
    @(posedge clk);
    cfg_write <= 1'b0;
    win_lo = lo;
    win_hi = hi;
    keep_fwd = fwd;
    qual_floor = floor_q;
  endtask

  // mostly well-formed reads around one spot of the window, with some noise
  task automatic run_reads(input int quota, input int focus, input int spread);
    int          stop_at;
    int          nb;
    int          pick;
    longint      anchor;
    logic [11:0] flags;
    logic [3:0]  kind;
    logic [27:0] len;
    bit          takes_bases;
    stop_at = beats_sent + quota;
    while (beats_sent < stop_at) begin
      if ($urandom_range(0, 99) < 5) begin
        send_beat(cmd_code_t'($urandom_range(0, 3)), 12'($urandom), 31'($urandom),
                  4'($urandom), 28'($urandom), 4'($urandom), 8'($urandom), 12'($urandom));
        continue;
      end
      if ($urandom_range(0, 99) < 80) begin
        flags = 12'($urandom) & ~FLAG_REJECT;
        flags = keep_fwd ? (flags & ~FLAG_REVERSE) : (flags | FLAG_REVERSE);
      end else begin
        flags = 12'($urandom);
      end
      anchor = longint'(win_lo) - 1 + focus + $urandom_range(0, spread);
      if (anchor < 0) anchor = 0;
      if (anchor > 2147483646) anchor = 2147483646;
      start_read(flags, anchor[30:0]);
      repeat ($urandom_range(1, 4)) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          case ($urandom_range(0, 2))
            0: kind = OP_M;
            1: kind = OP_EQ;
            default: kind = OP_X;
          endcase
        end else if (pick < 70) begin
          kind = $urandom_range(0, 1) ? OP_I : OP_S;
        end else if (pick < 85) begin
          kind = $urandom_range(0, 1) ? OP_D : OP_N;
        end else begin
          kind = 4'($urandom_range(OP_H, 4'hF));
        end
        takes_bases = (kind == OP_M || kind == OP_EQ || kind == OP_X ||
                       kind == OP_I || kind == OP_S);
        if ($urandom_range(0, 99) < 4) begin
          len = 28'($urandom);
        end else begin
          len = takes_bases ? 28'($urandom_range(0, 10)) : 28'($urandom_range(0, 25));
        end
        send_cigar(kind, len);
        if (takes_bases) begin
          nb = (len <= 12 && $urandom_range(0, 99) < 80) ? int'(len) : $urandom_range(0, 14);
        end else begin
          nb = ($urandom_range(0, 99) < 10) ? $urandom_range(1, 2) : 0;
        end
        repeat (nb) begin
          send_base(($urandom_range(0, 99) < 15) ? BASE_N : 4'($urandom_range(0, 14)),
                    $urandom_range(0, 1) ? 8'($urandom_range(0, 100)) : 8'($urandom));
        end
      end
      if ($urandom_range(0, 99) < 40) begin
        repeat ($urandom_range(1, 3)) begin
          send_readout(($urandom_range(0, 99) < 60) ?
                       12'(focus + $urandom_range(0, spread + 30)) : 12'($urandom));
        end
      end
    end
  endtask

  task automatic test_flag_and_base_filters();
    start_read(12'hFFF, 31'h7FFF_FFFE);
    send_cigar(OP_M, 28'hFFF_FFFF);
    send_base(4'd0, 8'hFF);
    start_read(12'h000, 31'd0);
    send_cigar(OP_X, 28'd3);
    send_base(BASE_N, 8'hFF);
    send_base(4'd0, {1'b0, MIN_QUAL_RST} - 8'd1);
    send_base(4'd14, {1'b0, MIN_QUAL_RST});
    send_base(4'd0, 8'hFF);
    send_readout(12'd2);
    send_readout(12'hFFF);
  endtask

  // cursor wraps at 2^32 to zero, just before the window; the second base lands on the first window position
  task automatic test_cursor_wrap();
    start_read(12'h0E3, 31'h7FFF_FFFE);
    repeat (4) begin
      send_cigar(OP_D, 28'hFFF_FFFF);
      send_cigar(OP_N, 28'hFFF_FFFF);
    end
    send_cigar(OP_D, 28'd9);
    send_cigar(OP_EQ, 28'd2);
    send_base(4'd1, 8'd40);
    send_base(4'd2, 8'd40);
    send_readout(12'd0);
  endtask

  task automatic test_forward_default_window();
    set_window(WINDOW_START_RST, WINDOW_END_RST, 1'b1, MIN_QUAL_RST);
    calm = 1'b1;
    run_reads(260, 0, 80);
    calm = 1'b0;
  endtask

  task automatic test_reverse_open_quality();
    set_window(31'd1, 31'd4096, 1'b0, 7'd0);
    run_reads(260, 4000, 120);
  endtask

  task automatic test_top_of_range_window();
    set_window(31'h7FFF_F000, 31'h7FFF_FFFF, 1'b1, 7'd93);
    run_reads(240, 4000, 100);
  endtask

  task automatic test_window_past_store();
    set_window(31'd100, 31'h7FFF_FFFF, 1'b0, 7'd30);
    run_reads(240, 4030, 100);
  endtask

  task automatic test_empty_window();
    set_window(31'd2000, 31'd1999, 1'b1, 7'd0);
    run_reads(200, 0, 40);
  endtask

  task automatic test_narrow_window();
    set_window(31'd500, 31'd510, 1'b1, 7'd20);
    run_reads(220, 0, 20);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_flag_and_base_filters();
    test_cursor_wrap();
    test_forward_default_window();
    test_reverse_open_quality();
    test_top_of_range_window();
    test_window_past_store();
    test_empty_window();
    test_narrow_window();
    settle();
    if (fault_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
